/* sv/pgm_p5_header_parser_defines.svh */
// Assertion macros for the P5 header parser.
`ifndef PGM_P5_HEADER_PARSER_DEFINES_SVH
`define PGM_P5_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define PGM_PH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pgm_ph assertion failed");
`define PGM_PH_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pgm_ph assertion failed");
`else
`define PGM_PH_ASSERT(label, clk, rst_n, prop)
`define PGM_PH_ASSERT_NORST(label, clk, prop)
`endif

`endif

/* sv/pgm_ph_pkg.sv */
`timescale 1ns / 1ps

package pgm_ph_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC1     = 4'd0,
        PH_MAGIC2_OK  = 4'd1,
        PH_W_WAIT     = 4'd2,
        PH_W_DIG      = 4'd3,
        PH_H_WAIT     = 4'd4,
        PH_H_DIG      = 4'd5,
        PH_M_WAIT     = 4'd6,
        PH_M_DIG      = 4'd7,
        PH_DONE       = 4'd8,
        PH_MAGIC2_BAD = 4'd9
    } phase_t;

    localparam logic [7:0]  CHAR_P     = 8'h50;
    localparam logic [7:0]  CHAR_5     = 8'h35;
    localparam logic [7:0]  CHAR_HASH  = 8'h23;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [30:0] TOKEN_MAX  = 31'h7FFF_FFFF;
    localparam logic [30:0] GREY_LIMIT = 31'd65535;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [30:0] image_width;
        logic [30:0] image_height;
        logic [30:0] max_grey;
        logic [31:0] header_length;
    } result_t;

endpackage

/* sv/pgm_ph_core.sv */
`timescale 1ns / 1ps
`include "pgm_p5_header_parser_defines.svh"

module pgm_ph_core
    import pgm_ph_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic        comment_reg, comment_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] width_reg, width_next;
    logic [30:0] height_reg, height_next;
    logic [31:0] count_reg, count_next;

    // state as seen after an optional restart
    phase_t      eff_phase;
    logic        eff_comment;
    logic [30:0] eff_acc;
    logic [30:0] eff_width;
    logic [30:0] eff_height;
    logic [31:0] eff_count;

    logic [7:0]  b;
    logic        eos;
    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [34:0] acc_sum;
    logic [30:0] acc_sat;
    logic [31:0] count_inc;
    logic        finish;
    logic        finish_ok;
    logic [31:0] res_count;

    assign eff_phase   = item.restart ? PH_MAGIC1 : phase_reg;
    assign eff_comment = item.restart ? 1'b0 : comment_reg;
    assign eff_acc     = item.restart ? 31'd0 : acc_reg;
    assign eff_width   = item.restart ? 31'd0 : width_reg;
    assign eff_height  = item.restart ? 31'd0 : height_reg;
    assign eff_count   = item.restart ? 32'd0 : count_reg;

    assign b        = item.data_byte;
    assign eos      = item.end_of_stream;
    assign is_space = (b == CHAR_SPACE) || (b inside {[CHAR_TAB:CHAR_CR]});
    assign is_digit = b inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit    = 4'(b - CHAR_ZERO);

    // acc * 10 + digit, saturating at 2^31-1
    assign acc_sum = {1'b0, eff_acc, 3'b000} + {3'b000, eff_acc, 1'b0} + {31'd0, digit};
    assign acc_sat = (|acc_sum[34:31]) ? TOKEN_MAX : acc_sum[30:0];

    assign count_inc  = (&eff_count) ? eff_count : eff_count + 32'd1;

    always_comb
    begin
        phase_next   = eff_phase;
        comment_next = eff_comment;
        acc_next     = eff_acc;
        width_next   = eff_width;
        height_next  = eff_height;
        count_next   = eff_count;
        if (eff_phase != PH_DONE)
        begin
            if (eos)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                count_next = count_inc;
                case (eff_phase)
                    PH_MAGIC1, PH_W_WAIT, PH_H_WAIT, PH_M_WAIT:
                    begin
                        if (eff_comment)
                        begin
                            if (b == CHAR_LF)
                                comment_next = 1'b0;
                        end
                        else if (is_space)
                        begin
                            phase_next = eff_phase;
                        end
                        else if (b == CHAR_HASH)
                        begin
                            comment_next = 1'b1;
                        end
                        else if (eff_phase == PH_MAGIC1)
                        begin
                            phase_next = (b == CHAR_P) ? PH_MAGIC2_OK : PH_MAGIC2_BAD;
                        end
                        else if (!is_digit)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            acc_next = {27'd0, digit};
                            case (eff_phase)
                                PH_W_WAIT: phase_next = PH_W_DIG;
                                PH_H_WAIT: phase_next = PH_H_DIG;
                                default:   phase_next = PH_M_DIG;
                            endcase
                        end
                    end
                    PH_MAGIC2_OK:
                    begin
                        phase_next = (b == CHAR_5) ? PH_W_WAIT : PH_DONE;
                    end
                    PH_W_DIG, PH_H_DIG, PH_M_DIG:
                    begin
                        if (is_digit)
                        begin
                            acc_next = acc_sat;
                        end
                        else if (eff_phase == PH_W_DIG)
                        begin
                            width_next = eff_acc;
                            acc_next   = 31'd0;
                            phase_next = PH_H_WAIT;
                        end
                        else if (eff_phase == PH_H_DIG)
                        begin
                            height_next = eff_acc;
                            acc_next    = 31'd0;
                            phase_next  = PH_M_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result_valid = 1'b0;
        finish       = 1'b0;
        if (step_en && (eff_phase != PH_DONE))
        begin
            if (eos)
            begin
                result_valid = 1'b1;
                finish       = (eff_phase == PH_M_DIG);
            end
            else
            begin
                case (eff_phase)
                    PH_MAGIC1, PH_W_WAIT, PH_H_WAIT, PH_M_WAIT:
                    begin
                        result_valid = !eff_comment && !is_space && (b != CHAR_HASH)
                                       && (eff_phase != PH_MAGIC1) && !is_digit;
                    end
                    PH_MAGIC2_OK:  result_valid = (b != CHAR_5);
                    PH_MAGIC2_BAD: result_valid = 1'b1;
                    PH_M_DIG:
                    begin
                        result_valid = !is_digit;
                        finish       = !is_digit;
                    end
                    default:       result_valid = 1'b0;
                endcase
            end
        end
    end

    assign res_count = eos ? eff_count : count_inc;
    assign finish_ok = finish && (eff_width != 31'd0) && (eff_height != 31'd0)
                       && (eff_acc != 31'd0) && (eff_acc <= GREY_LIMIT);

    always_comb
    begin
        if (finish_ok)
        begin
            result.status        = 1'b0;
            result.image_width   = eff_width;
            result.image_height  = eff_height;
            result.max_grey      = eff_acc;
            result.header_length = res_count;
        end
        else
        begin
            result.status        = 1'b1;
            result.image_width   = 31'd0;
            result.image_height  = 31'd0;
            result.max_grey      = 31'd0;
            result.header_length = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC1;
            comment_reg <= 1'b0;
            acc_reg     <= 31'd0;
            width_reg   <= 31'd0;
            height_reg  <= 31'd0;
            count_reg   <= 32'd0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            acc_reg     <= acc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            count_reg   <= count_next;
        end
    end

    `PGM_PH_ASSERT_NORST(a_result_needs_step, clk, !step_en |-> !result_valid)
    `PGM_PH_ASSERT(a_result_ends_header, clk, rst_n,
        step_en && result_valid |=> phase_reg == PH_DONE)
    `PGM_PH_ASSERT(a_good_grey_range, clk, rst_n,
        result_valid && !result.status |-> result.max_grey != 31'd0
            && result.max_grey <= GREY_LIMIT && result.image_width != 31'd0)
    `PGM_PH_ASSERT(a_error_zeroed, clk, rst_n,
        result_valid && result.status |-> result.header_length == 32'd0
            && result.max_grey == 31'd0)

endmodule

/* sv/pgm_p5_header_parser.sv */
`timescale 1ns / 1ps
// channel  | group  | tdata                         | tuser
// ---------+--------+-------------------------------+------------------------------
// bytes in | s_axis | data_byte                     | end_of_stream, restart
// result   | m_axis | width, height, maxgrey, length| status
//
// One byte per cycle sustained unless m_axis stalls; a byte is registered,
// then parsed once the result register is free; any result is registered.
// rst_n is asynchronous and returns the parser to the start of a header.
// The input register drains whenever the result register is empty or taken,
// so a stalled result holds back at most one buffered byte.

module pgm_p5_header_parser
    import pgm_ph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_axis_tuser,   // [0] end_of_stream, [1] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [30:0] image_width, [61:31] image_height, [92:62] max_grey,
    // [124:93] header_length, [127:125] zero
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tuser    // [0] status
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    logic    s_fire;
    logic    proc_fire;
    logic    res_valid;
    result_t res;

    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    pgm_ph_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (proc_fire),
        .item         (in_item_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire && res_valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.data_byte     <= s_axis_tdata;
            in_item_reg.end_of_stream <= s_axis_tuser[0];
            in_item_reg.restart       <= s_axis_tuser[1];
        end
        if (proc_fire && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {3'b000, out_res_reg.header_length, out_res_reg.max_grey,
                            out_res_reg.image_height, out_res_reg.image_width};

endmodule

/* tb/pgm_p5_header_parser_tb.sv */
`timescale 1ns / 1ps

module pgm_p5_header_parser_tb;
    import pgm_ph_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 500;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic [1:0]   s_axis_tuser  = 2'd0;   // [0] end_of_stream, [1] restart
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [30:0] image_width, [61:31] image_height, [92:62] max_grey, [124:93] header_length
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;           // [0] status

    pgm_p5_header_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int mismatches = 0;
    int checked   = 0;
    int live_items = 0;
    int hdr_ok    = 0;
    int hdr_bad   = 0;

    result_t pending_headers[$];
    item_t   hdr_seq[$];

    // parser shadow state
    phase_t      hdr_phase      = PH_MAGIC1;
    logic        hdr_in_comment = 1'b0;
    logic [30:0] hdr_acc        = '0;
    logic [30:0] hdr_width      = '0;
    logic [30:0] hdr_height     = '0;
    logic [31:0] hdr_bytes      = '0;

    function automatic bit is_dec_digit(input logic [7:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    function automatic void clear_parser();
        hdr_phase      = PH_MAGIC1;
        hdr_in_comment = 1'b0;
        hdr_acc        = '0;
        hdr_width      = '0;
        hdr_height     = '0;
        hdr_bytes      = '0;
    endfunction

    function automatic void reject_header();
        pending_headers.push_back(result_t'{1'b1, 31'd0, 31'd0, 31'd0, 32'd0});
        hdr_bad++;
        hdr_phase = PH_DONE;
    endfunction

    function automatic void close_header();
        if (hdr_width == 0 || hdr_height == 0 || hdr_acc == 0 || hdr_acc > GREY_LIMIT)
        begin
            reject_header();
        end
        else
        begin
            pending_headers.push_back(result_t'{1'b0, hdr_width, hdr_height, hdr_acc,
                                                hdr_bytes});
            hdr_ok++;
            hdr_phase = PH_DONE;
        end
    endfunction

    function automatic void parse_header_byte(input item_t it);
        logic [34:0] nxt;
        logic [7:0]  b;
        b = it.data_byte;
        if (it.restart)
            clear_parser();
        if (hdr_phase == PH_DONE)
            return;
        if (it.end_of_stream)
        begin
            if (hdr_phase == PH_M_DIG)
                close_header();
            else
                reject_header();
            return;
        end
        if (hdr_bytes != 32'hFFFF_FFFF)
            hdr_bytes++;
        case (hdr_phase)
            PH_MAGIC1, PH_W_WAIT, PH_H_WAIT, PH_M_WAIT:
            begin
                if (hdr_in_comment)
                begin
                    if (b == CHAR_LF)
                        hdr_in_comment = 1'b0;
                end
                else if (is_blank(b))
                begin
                end
                else if (b == CHAR_HASH)
                    hdr_in_comment = 1'b1;
                else if (hdr_phase == PH_MAGIC1)
                    hdr_phase = (b == CHAR_P) ? PH_MAGIC2_OK : PH_MAGIC2_BAD;
                else if (!is_dec_digit(b))
                    reject_header();
                else
                begin
                    hdr_acc   = 31'(b - CHAR_ZERO);
                    hdr_phase = phase_t'(hdr_phase + 4'd1);
                end
            end
            PH_MAGIC2_OK:
            begin
                if (b == CHAR_5)
                    hdr_phase = PH_W_WAIT;
                else
                    reject_header();
            end
            PH_MAGIC2_BAD:
                reject_header();
            PH_W_DIG, PH_H_DIG, PH_M_DIG:
            begin
                if (is_dec_digit(b))
                begin
                    nxt = {4'd0, hdr_acc} * 35'd10 + 35'(b - CHAR_ZERO);
                    hdr_acc = (nxt > 35'(TOKEN_MAX)) ? TOKEN_MAX : nxt[30:0];
                end
                else if (hdr_phase == PH_W_DIG)
                begin
                    hdr_width = hdr_acc;
                    hdr_acc   = '0;
                    hdr_phase = PH_H_WAIT;
                end
                else if (hdr_phase == PH_H_DIG)
                begin
                    hdr_height = hdr_acc;
                    hdr_acc    = '0;
                    hdr_phase  = PH_M_WAIT;
                end
                else
                    close_header();
            end
            default:
                hdr_phase = PH_DONE;
        endcase
    endfunction

    // ---------------- result checking ----------------
    function automatic void compare_field(input string name, input logic [31:0] got,
                                          input logic [31:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void check_result(input result_t got);
        result_t want;
        if (pending_headers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: status %0d length %0d",
                         got.status, got.header_length);
            return;
        end
        want = pending_headers.pop_front();
        checked++;
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("image_width", 32'(got.image_width), 32'(want.image_width));
        compare_field("image_height", 32'(got.image_height), 32'(want.image_height));
        compare_field("max_grey", 32'(got.max_grey), 32'(want.max_grey));
        compare_field("header_length", got.header_length, want.header_length);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(result_t'{m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[61:31],
                                   m_axis_tdata[92:62], m_axis_tdata[124:93]});
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_headers.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // one request per accepted byte
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data_byte;
        s_axis_tuser  <= {it.restart, it.end_of_stream};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (it.restart || hdr_phase != PH_DONE)
            live_items++;
        parse_header_byte(it);
    endtask

    task automatic send_text(input string s, input bit fresh);
        for (int i = 0; i < s.len(); i++)
            send_item(item_t'{data_byte: s[i], end_of_stream: 1'b0,
                              restart: fresh && i == 0});
    endtask

    task automatic send_raw(input logic [7:0] b);
        send_item(item_t'{data_byte: b, end_of_stream: 1'b0, restart: 1'b0});
    endtask

    task automatic send_eos(input bit fresh);
        send_item(item_t'{data_byte: 8'($urandom), end_of_stream: 1'b1, restart: fresh});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_headers.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] b);
        hdr_seq.push_back(item_t'{data_byte: b, end_of_stream: 1'b0, restart: 1'b0});
    endfunction

    function automatic void push_eos();
        hdr_seq.push_back(item_t'{data_byte: 8'($urandom), end_of_stream: 1'b1,
                                  restart: 1'b0});
    endfunction

    function automatic void add_gap();
        logic [7:0] b;
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(3) == 0)
            begin
                push_byte(CHAR_HASH);
                repeat ($urandom_range(4))
                begin
                    do b = 8'($urandom); while (b == CHAR_LF);
                    push_byte(b);
                end
                push_byte(CHAR_LF);
            end
            else
            begin
                b = 8'($urandom_range(6));
                push_byte(b == 8'd6 ? CHAR_SPACE : CHAR_TAB + b);
            end
        end
    endfunction

    function automatic void add_number(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void add_token(input int which);
        int k;
        k = $urandom_range(15);
        if (k == 0)
            push_byte(CHAR_ZERO);
        else if (k == 1)
            repeat ($urandom_range(10, 14))
                push_byte(CHAR_ZERO + 8'($urandom_range(9)));
        else if (k == 2 && which == 2)
            add_number($urandom_range(65536, 999999));
        else if (k == 3 && which == 2)
            add_number(GREY_LIMIT);
        else
        begin
            if (k == 4)
                push_byte(CHAR_ZERO);
            add_number($urandom_range(1, k < 9 ? 9 : 999));
        end
    endfunction

    function automatic void add_terminator();
        logic [7:0] b;
        if ($urandom_range(1))
            b = CHAR_SPACE;
        else
            do b = 8'($urandom); while (is_dec_digit(b));
        push_byte(b);
    endfunction

    task automatic send_random_header();
        int m;
        int pos;
        hdr_seq.delete();
        m = $urandom_range(9);
        if (m == 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(7) == 0)
                    push_eos();
                else
                    push_byte(8'($urandom));
            end
        end
        else
        begin
            if ($urandom_range(1))
                add_gap();
            push_byte(CHAR_P);
            push_byte(CHAR_5);
            for (int t = 0; t < 3; t++)
            begin
                if (t > 0 || $urandom_range(1))
                    add_gap();
                add_token(t);
                if (t < 2 || $urandom_range(3) != 0)
                    add_terminator();
                else
                    push_eos();
            end
            pos = $urandom_range(hdr_seq.size() - 1);
            if (m == 1)
                hdr_seq[pos].data_byte = 8'($urandom);
            else if (m == 2)
            begin
                while (hdr_seq.size() > pos)
                    void'(hdr_seq.pop_back());
                push_eos();
            end
            else if (m == 3)
                hdr_seq[pos].restart = 1'b1;
        end
        hdr_seq[0].restart = 1'b1;
        repeat ($urandom_range(2))
            push_byte(8'($urandom));
        foreach (hdr_seq[i])
            send_item(hdr_seq[i]);
    endtask

    // ---------------- tests ----------------
    task automatic test_magic();
        send_text(" \t#x\nP5 3 2 255\n", 1'b1);
        send_text("Q5", 1'b1);
        send_text("P6", 1'b1);
    endtask

    task automatic test_tokens();
        send_text("P5x", 1'b1);
        send_text("P5 4294967296 1\01565535Z", 1'b1);
        send_text("P57", 1'b1);
        send_raw(8'h00);
        send_text("8\0139", 1'b0);
        send_raw(8'hFF);
    endtask

    task automatic test_end_of_stream();
        send_eos(1'b1);
        send_text("P5 1 1 65535", 1'b1);
        send_eos(1'b0);
        send_text("P5 1 1", 1'b1);
        send_eos(1'b0);
        send_text(" 9 9\n", 1'b0);
    endtask

    task automatic test_range();
        send_text("P5 0 1 1 ", 1'b1);
        send_text("P5 1 0 1 ", 1'b1);
        send_text("P5 1 1 0 ", 1'b1);
        send_text("P5 1 1 65536 ", 1'b1);
    endtask

    task automatic test_restart();
        send_text("P5 12 ", 1'b1);
        send_text("P5 1 2 3 ", 1'b1);
    endtask

    task automatic test_random(input int src_pct, input int snk_pct);
        int start;
        idle_pct  = src_pct;
        stall_pct = snk_pct;
        start = live_items;
        while (live_items - start < PHASE_ITEMS)
            send_random_header();
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_magic();
        test_tokens();
        test_end_of_stream();
        test_range();
        test_restart();
        wait_idle();

        test_random(0, 0);
        test_random(54, 0);
        test_random(0, 54);
        test_random(10, 10);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d header bytes parsed under four idle/stall mixes", live_items);
        $display("%0d results checked: %0d headers accepted, %0d rejected",
                 checked, hdr_ok, hdr_bad);
        if (mismatches == 0 && pending_headers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
